>>> hw/rtl/tsw_pkg.sv
// tsw_pkg: shared constants and types of the task supervision watchdog
// item kinds, status codes, sequencer states and the default slot count
// no dependencies; compiled first
package tsw_pkg;

    // default number of supervised slots
    localparam int TSW_SLOTS = 8;

    // item kinds
    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_REGISTER = 3'd1;
    localparam logic [2:0] KIND_FEED     = 3'd2;
    localparam logic [2:0] KIND_SERVICE  = 3'd3;
    localparam logic [2:0] KIND_STATUS   = 3'd4;

    // result status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_INVALID  = 3'd1;
    localparam logic [2:0] STAT_NOT_REG  = 3'd2;
    localparam logic [2:0] STAT_NO_SLOT  = 3'd3;
    localparam logic [2:0] STAT_EXPIRED  = 3'd4;
    localparam logic [2:0] STAT_NOT_INIT = 3'd5;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } tsw_state_t;

endpackage

>>> hw/rtl/tsw_if.sv
// tsw_if: valid/ready channel interfaces of the task supervision watchdog
// item channel, result channel and configuration write channel
// no dependencies
interface tsw_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] timeout_val;
    logic [7:0]  slot_index;

    modport source (output valid, kind, timeout_val, slot_index, input ready);
    modport sink   (input valid, kind, timeout_val, slot_index, output ready);
endinterface

interface tsw_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status_code;
    logic [7:0]  slot_result;
    logic        kick;
    logic        all_healthy;
    logic [7:0]  active_count;
    logic [31:0] feed_total;
    logic [31:0] last_service_time;

    modport source (output valid, status_code, slot_result, kick, all_healthy,
                    active_count, feed_total, last_service_time, input ready);
    modport sink   (input valid, status_code, slot_result, kick, all_healthy,
                    active_count, feed_total, last_service_time, output ready);
endinterface

interface tsw_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/task_supervision_watchdog_top.sv
// task_supervision_watchdog_top: top level of the task supervision watchdog
// depends on tsw_pkg, tsw_if, tsw_slot_mem and tsw_seq
//
// Usage
//   item   : valid/ready channel of input transactions (kind, timeout_val,
//            slot_index); kinds are tick, register task, feed task, service
//            feed and status
//   result : valid/ready channel, exactly one result transaction per item
//   cfg    : one-bit write channel for the enabled bit, always ready; write
//            it only while no item is in flight
// Timing
//   tick, feed-task, rejected and unknown items pass from the idle state
//   straight to the done state and on into the output register; register,
//   service-feed and status items first walk the slot table through the
//   single read port of the slot store and the shared age/timeout
//   comparator, one slot per cycle, before the done state; a register item
//   stops at the first free slot and a service feed at the first expired slot
//   a new item is accepted only while the sequencer is idle
// Reset and stall
//   reset clears uptime, feed counters, active marks and enabled; the slot
//   store needs no clearing since an entry is written when claimed
//   the output register lets the next item be accepted while a result
//   waits; a stalled receiver holds the sequencer after that item finishes
module task_supervision_watchdog_top #(
    parameter int SLOTS = tsw_pkg::TSW_SLOTS
) (
    input  logic          clk,
    input  logic          rst_n,
    tsw_cfg_if.sink       cfg,
    tsw_item_if.sink      item,
    tsw_result_if.source  result
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic          enabled_reg;
    logic          mem_we_tmo;
    logic          mem_we_feed;
    logic [SW-1:0] mem_waddr;
    logic [31:0]   mem_wtmo;
    logic [31:0]   mem_wfeed;
    logic [SW-1:0] mem_raddr;
    logic [31:0]   mem_rtmo;
    logic [31:0]   mem_rfeed;

    // enabled register, written by a cfg transaction
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            enabled_reg <= cfg.data;
        end
    end

    // slot timeout and last-feed store
    tsw_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .clk     (clk),
        .we_tmo  (mem_we_tmo),
        .we_feed (mem_we_feed),
        .waddr   (mem_waddr),
        .wtmo    (mem_wtmo),
        .wfeed   (mem_wfeed),
        .raddr   (mem_raddr),
        .rtmo    (mem_rtmo),
        .rfeed   (mem_rfeed)
    );

    // sequencer with shared expiry compare
    tsw_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .enabled     (enabled_reg),
        .item        (item),
        .result      (result),
        .mem_we_tmo  (mem_we_tmo),
        .mem_we_feed (mem_we_feed),
        .mem_waddr   (mem_waddr),
        .mem_wtmo    (mem_wtmo),
        .mem_wfeed   (mem_wfeed),
        .mem_raddr   (mem_raddr),
        .mem_rtmo    (mem_rtmo),
        .mem_rfeed   (mem_rfeed)
    );

endmodule

>>> hw/rtl/tsw_slot_mem.sv
// tsw_slot_mem: per-slot timeout and last-feed store
// one write address with separate field enables, one registered read port
// no dependencies
module tsw_slot_mem #(
    parameter int SLOTS = 8
) (
    input  logic                                       clk,
    input  logic                                       we_tmo,
    input  logic                                       we_feed,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr,
    input  logic [31:0]                                wtmo,
    input  logic [31:0]                                wfeed,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
    output logic [31:0]                                rtmo,
    output logic [31:0]                                rfeed
);

    logic [31:0] tmo_mem  [SLOTS];
    logic [31:0] feed_mem [SLOTS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we_tmo)
        begin
            tmo_mem[waddr] <= wtmo;
        end
        if (we_feed)
        begin
            feed_mem[waddr] <= wfeed;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rtmo  <= tmo_mem[raddr];
        rfeed <= feed_mem[raddr];
    end

endmodule

>>> hw/rtl/tsw_seq.sv
// tsw_seq: sequencer, slot scan and expiry compare of the task watchdog
// depends on tsw_pkg, tsw_if and the slot store read/write signals
// holds uptime, feed counters, active bits and the result register
module tsw_seq #(
    parameter int SLOTS = tsw_pkg::TSW_SLOTS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       enabled,
    tsw_item_if.sink                                   item,
    tsw_result_if.source                               result,
    output logic                                       mem_we_tmo,
    output logic                                       mem_we_feed,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] mem_waddr,
    output logic [31:0]                                mem_wtmo,
    output logic [31:0]                                mem_wfeed,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] mem_raddr,
    input  logic [31:0]                                mem_rtmo,
    input  logic [31:0]                                mem_rfeed
);

    import tsw_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    tsw_state_t        state_reg, state_next;
    logic [31:0]       uptime_reg, uptime_next;
    logic [31:0]       feeds_reg, feeds_next;
    logic [31:0]       stime_reg, stime_next;
    logic [SLOTS-1:0]  active_reg, active_next;
    logic [2:0]        kind_reg, kind_next;
    logic [31:0]       tmo_reg, tmo_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              pipe_valid_reg, pipe_valid_next;
    logic [SW-1:0]     pipe_idx_reg, pipe_idx_next;
    logic              found_reg, found_next;
    logic [SW-1:0]     first_reg, first_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [2:0]        w_code_reg, w_code_next;
    logic [7:0]        w_slot_reg, w_slot_next;
    logic              w_kick_reg, w_kick_next;
    logic              w_healthy_reg, w_healthy_next;
    logic [7:0]        w_count_reg, w_count_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_code_reg, out_code_next;
    logic [7:0]        out_slot_reg, out_slot_next;
    logic              out_kick_reg, out_kick_next;
    logic              out_healthy_reg, out_healthy_next;
    logic [7:0]        out_count_reg, out_count_next;
    logic [31:0]       out_feeds_reg, out_feeds_next;
    logic [31:0]       out_stime_reg, out_stime_next;

    logic        accept;
    logic        out_free;
    logic        idx_ok;
    logic        feed_hit;
    logic        pipe_act;
    logic [31:0] age;
    logic        pipe_exp;
    logic        pipe_last;
    logic        claim;
    logic        svc_exp;
    logic        scan_end;
    logic        goes_scan;

    // handshake
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    // feed-task slot check
    assign idx_ok   = item.slot_index < 8'(SLOTS);
    assign feed_hit = idx_ok && active_reg[item.slot_index[SW-1:0]];

    // shared expiry compare on the registered slot entry
    assign pipe_act  = pipe_valid_reg && active_reg[pipe_idx_reg];
    assign age       = uptime_reg - mem_rfeed;
    assign pipe_exp  = pipe_act && (age > mem_rtmo);
    assign pipe_last = pipe_valid_reg && (pipe_idx_reg == SW'(SLOTS - 1));
    assign claim     = (kind_reg == KIND_REGISTER) && pipe_valid_reg && !pipe_act;
    assign svc_exp   = (kind_reg == KIND_SERVICE) && pipe_exp;
    assign scan_end  = claim || svc_exp || pipe_last;

    // kinds that need a pass over the slots
    assign goes_scan = ((item.kind == KIND_REGISTER) && (item.timeout_val != 32'd0))
                    || ((item.kind == KIND_SERVICE) && enabled)
                    || (item.kind == KIND_STATUS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = goes_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        uptime_next      = uptime_reg;
        feeds_next       = feeds_reg;
        stime_next       = stime_reg;
        active_next      = active_reg;
        kind_next        = kind_reg;
        tmo_next         = tmo_reg;
        rd_idx_next      = rd_idx_reg;
        pipe_valid_next  = pipe_valid_reg;
        pipe_idx_next    = pipe_idx_reg;
        found_next       = found_reg;
        first_next       = first_reg;
        cnt_next         = cnt_reg;
        w_code_next      = w_code_reg;
        w_slot_next      = w_slot_reg;
        w_kick_next      = w_kick_reg;
        w_healthy_next   = w_healthy_reg;
        w_count_next     = w_count_reg;
        out_code_next    = out_code_reg;
        out_slot_next    = out_slot_reg;
        out_kick_next    = out_kick_reg;
        out_healthy_next = out_healthy_reg;
        out_count_next   = out_count_reg;
        out_feeds_next   = out_feeds_reg;
        out_stime_next   = out_stime_reg;
        mem_we_tmo       = 1'b0;
        mem_we_feed      = 1'b0;
        mem_waddr        = pipe_idx_reg;
        mem_wtmo         = tmo_reg;
        mem_wfeed        = uptime_reg;
        mem_raddr        = rd_idx_reg[SW-1:0];

        // result transaction drains the output register
        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = item.kind;
                    tmo_next        = item.timeout_val;
                    rd_idx_next     = '0;
                    pipe_valid_next = 1'b0;
                    found_next      = 1'b0;
                    cnt_next        = '0;
                    w_code_next     = STAT_OK;
                    w_slot_next     = 8'd0;
                    w_kick_next     = 1'b0;
                    w_healthy_next  = 1'b0;
                    w_count_next    = 8'd0;
                    case (item.kind)
                        KIND_TICK:
                        begin
                            uptime_next = uptime_reg + 32'd1;
                        end
                        KIND_REGISTER:
                        begin
                            if (item.timeout_val == 32'd0)
                            begin
                                w_code_next = STAT_INVALID;
                            end
                        end
                        KIND_FEED:
                        begin
                            if (!idx_ok)
                            begin
                                w_code_next = STAT_INVALID;
                            end
                            else if (!feed_hit)
                            begin
                                w_code_next = STAT_NOT_REG;
                            end
                            else
                            begin
                                mem_we_feed = 1'b1;
                                mem_waddr   = item.slot_index[SW-1:0];
                            end
                        end
                        KIND_SERVICE:
                        begin
                            if (!enabled)
                            begin
                                w_code_next = STAT_NOT_INIT;
                            end
                        end
                        KIND_STATUS:
                        begin
                            w_code_next = STAT_OK;
                        end
                        default:
                        begin
                            w_code_next = STAT_INVALID;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue the next slot read
                if (rd_idx_reg < CW'(SLOTS))
                begin
                    rd_idx_next     = rd_idx_reg + CW'(1);
                    pipe_valid_next = 1'b1;
                    pipe_idx_next   = rd_idx_reg[SW-1:0];
                end
                else
                begin
                    pipe_valid_next = 1'b0;
                end

                // track first expired slot and active count
                if (pipe_exp && !found_reg)
                begin
                    found_next = 1'b1;
                    first_next = pipe_idx_reg;
                end
                if (pipe_act)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end

                // close the scan
                if (claim)
                begin
                    active_next[pipe_idx_reg] = 1'b1;
                    mem_we_tmo  = 1'b1;
                    mem_we_feed = 1'b1;
                    w_code_next = STAT_OK;
                    w_slot_next = 8'(pipe_idx_reg);
                end
                else if (svc_exp)
                begin
                    w_code_next = STAT_EXPIRED;
                    w_slot_next = 8'(pipe_idx_reg);
                end
                else if (pipe_last)
                begin
                    case (kind_reg)
                        KIND_REGISTER:
                        begin
                            w_code_next = STAT_NO_SLOT;
                        end
                        KIND_SERVICE:
                        begin
                            w_kick_next = 1'b1;
                            feeds_next  = feeds_reg + 32'd1;
                            stime_next  = uptime_reg;
                        end
                        KIND_STATUS:
                        begin
                            w_healthy_next = !(found_reg || pipe_exp);
                            if (found_reg)
                            begin
                                w_slot_next = 8'(first_reg);
                            end
                            else if (pipe_exp)
                            begin
                                w_slot_next = 8'(pipe_idx_reg);
                            end
                            w_count_next = 8'(cnt_reg + CW'(pipe_act));
                        end
                        default:
                        begin
                            w_code_next = STAT_INVALID;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                // load the output register once it is free
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_code_next    = w_code_reg;
                    out_slot_next    = w_slot_reg;
                    out_kick_next    = w_kick_reg;
                    out_healthy_next = w_healthy_reg;
                    out_count_next   = w_count_reg;
                    out_feeds_next   = feeds_reg;
                    out_stime_next   = stime_reg;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            uptime_reg     <= 32'd0;
            feeds_reg      <= 32'd0;
            stime_reg      <= 32'd0;
            active_reg     <= '0;
            rd_idx_reg     <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            uptime_reg     <= uptime_next;
            feeds_reg      <= feeds_next;
            stime_reg      <= stime_next;
            active_reg     <= active_next;
            rd_idx_reg     <= rd_idx_next;
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        tmo_reg         <= tmo_next;
        pipe_idx_reg    <= pipe_idx_next;
        found_reg       <= found_next;
        first_reg       <= first_next;
        cnt_reg         <= cnt_next;
        w_code_reg      <= w_code_next;
        w_slot_reg      <= w_slot_next;
        w_kick_reg      <= w_kick_next;
        w_healthy_reg   <= w_healthy_next;
        w_count_reg     <= w_count_next;
        out_code_reg    <= out_code_next;
        out_slot_reg    <= out_slot_next;
        out_kick_reg    <= out_kick_next;
        out_healthy_reg <= out_healthy_next;
        out_count_reg   <= out_count_next;
        out_feeds_reg   <= out_feeds_next;
        out_stime_reg   <= out_stime_next;
    end

    // result channel
    assign result.valid             = out_valid_reg;
    assign result.status_code       = out_code_reg;
    assign result.slot_result       = out_slot_reg;
    assign result.kick              = out_kick_reg;
    assign result.all_healthy       = out_healthy_reg;
    assign result.active_count      = out_count_reg;
    assign result.feed_total        = out_feeds_reg;
    assign result.last_service_time = out_stime_reg;

    // scan read pointer never runs past the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_idx_reg <= CW'(SLOTS)))
        else $error("scan read pointer beyond slot table");

    // compare stage only ever sees a slot inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> (pipe_idx_reg <= SW'(SLOTS - 1)))
        else $error("compare stage slot out of range");

    // a claim only writes a free slot and marks it active
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we_tmo |-> (!active_reg[mem_waddr] ##1 active_reg[$past(mem_waddr)]))
        else $error("claim did not take a free slot");

    // a kick is only given with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kick_reg) |-> (out_code_reg == STAT_OK))
        else $error("kick with failing status");

    // feed counter moves only at the end of a service scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (feeds_reg != $past(feeds_reg)) |-> ($past(state_reg) == ST_SCAN
            && $past(kind_reg) == KIND_SERVICE))
        else $error("feed counter changed outside a service scan");

endmodule
